@@ rtl/swagc_pkg.sv @@
// ----------------------------------------------------------------------------
// swagc_pkg: shared types and constants of the sliding window agc
// widths, sequencer states, divider request/response and sample magnitude
// ----------------------------------------------------------------------------
package swagc_pkg;

	// field widths and window limits
	localparam int MAX_HALF_WINDOW = 512;
	localparam int SAMPLE_BITS     = 24;
	localparam int FRAC_BITS       = 16;
	localparam int OUT_BITS        = 28;
	localparam int CFG_BITS        = 10;
	localparam int CTR_BITS        = 32;

	// derived widths
	localparam int HW_BITS   = $clog2(MAX_HALF_WINDOW + 1);
	localparam int ADDR_BITS = $clog2(2 * MAX_HALF_WINDOW);
	localparam int CNT_BITS  = $clog2(2 * MAX_HALF_WINDOW + 1);
	localparam int SUM_BITS  = SAMPLE_BITS - 1 + CNT_BITS;
	localparam int PROD_BITS = SAMPLE_BITS + CNT_BITS;
	localparam int INT_BITS  = OUT_BITS - 1 - FRAC_BITS;
	localparam int CMP_BITS  = SUM_BITS + INT_BITS;
	localparam int ITER_BITS = $clog2(OUT_BITS);

	localparam logic [CFG_BITS-1:0] HALF_WINDOW_RESET = CFG_BITS'(64);

	// request type codes
	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_DRAIN  = 1'b1;

	// main sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_RD_CUR,
		S_RD_OLD,
		S_START,
		S_DIV,
		S_OUT
	} seq_state_t;

	// divider states
	typedef enum logic [2:0] {
		D_IDLE,
		D_MUL,
		D_CHK,
		D_ITER,
		D_DONE
	} div_state_t;

	// divider command
	typedef struct packed {
		logic                          start;
		logic signed [SAMPLE_BITS-1:0] sample;
		logic [CNT_BITS-1:0]           count;
		logic [SUM_BITS-1:0]           sum;
	} div_req_t;

	// divider answer
	typedef struct packed {
		logic                       done;
		logic signed [OUT_BITS-1:0] result;
	} div_rsp_t;

	// absolute value of a sample, exact for the most negative code
	function automatic logic [SAMPLE_BITS-1:0] sample_mag(
		input logic signed [SAMPLE_BITS-1:0] s
	);
		if (s[SAMPLE_BITS-1]) begin
			return SAMPLE_BITS'(-s);
		end
		return SAMPLE_BITS'(s);
	endfunction

endpackage

@@ rtl/swagc_in_if.sv @@
// ----------------------------------------------------------------------------
// swagc_in_if: input channel of the sliding window agc
// valid/ready handshake carrying one sample or drain request
// ----------------------------------------------------------------------------
interface swagc_in_if
	import swagc_pkg::*;
;
	logic                          valid;
	logic                          ready;
	logic                          req_type;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          trace_last;

	modport source (output valid, output req_type, output sample, output trace_last,
		input ready);
	modport sink (input valid, input req_type, input sample, input trace_last,
		output ready);
endinterface

@@ rtl/swagc_out_if.sv @@
// ----------------------------------------------------------------------------
// swagc_out_if: output channel of the sliding window agc
// valid/ready handshake carrying one gained sample
// ----------------------------------------------------------------------------
interface swagc_out_if
	import swagc_pkg::*;
;
	logic                       valid;
	logic                       ready;
	logic signed [OUT_BITS-1:0] gained_sample;
	logic                       out_last;

	modport source (output valid, output gained_sample, output out_last, input ready);
	modport sink (input valid, input gained_sample, input out_last, output ready);
endinterface

@@ rtl/swagc_div.sv @@
// ----------------------------------------------------------------------------
// swagc_div: shared gain unit
// count*|sample| over the absolute sum, one quotient bit per cycle by
// restoring division, rounded to nearest and saturated to signed Q11.16
// ----------------------------------------------------------------------------
module swagc_div
	import swagc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam logic [OUT_BITS-1:0] OUT_MAX_MAG = {1'b0, {(OUT_BITS-1){1'b1}}};
	localparam logic [OUT_BITS-1:0] OUT_MIN_MAG = {1'b1, {(OUT_BITS-1){1'b0}}};

	div_state_t               state_q, state_d;
	logic [SAMPLE_BITS-1:0]   mag_q;
	logic                     neg_q;
	logic                     zero_q;
	logic                     ovf_q;
	logic [CNT_BITS-1:0]      cnt_q;
	logic [SUM_BITS-1:0]      sum_q;
	logic [PROD_BITS-1:0]     prod_q;
	logic [SUM_BITS:0]        rem_q;
	logic [OUT_BITS-1:0]      dsh_q;
	logic [OUT_BITS-1:0]      quo_q;
	logic [ITER_BITS-1:0]     iter_q;
	logic                     done_q;
	logic signed [OUT_BITS-1:0] res_q;

	logic                     ovf;
	logic [SUM_BITS:0]        trial;
	logic                     qbit;
	logic [OUT_BITS:0]        rnd;
	logic [OUT_BITS-1:0]      qmag;
	logic [OUT_BITS-1:0]      res_d;

	// overflow check: integer part would not fit
	assign ovf = CMP_BITS'(prod_q) >= {sum_q, {INT_BITS{1'b0}}};

	// one restoring step
	assign trial = {rem_q[SUM_BITS-1:0], dsh_q[OUT_BITS-1]};
	assign qbit  = trial >= {1'b0, sum_q};

	// rounding, saturation and sign
	always_comb begin
		rnd  = (OUT_BITS+1)'(quo_q) + (OUT_BITS+1)'(1);
		qmag = ovf_q ? OUT_MIN_MAG : rnd[OUT_BITS:1];
		if (zero_q) begin
			res_d = '0;
		end else if (!neg_q) begin
			res_d = (qmag > OUT_MAX_MAG) ? OUT_MAX_MAG : qmag;
		end else begin
			res_d = OUT_BITS'(-qmag);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			D_IDLE: begin
				if (req.start) state_d = D_MUL;
			end
			D_MUL: state_d = D_CHK;
			D_CHK: begin
				if (zero_q || ovf) state_d = D_DONE;
				else state_d = D_ITER;
			end
			D_ITER: begin
				if (iter_q == ITER_BITS'(OUT_BITS - 1)) state_d = D_DONE;
			end
			D_DONE: state_d = D_IDLE;
			default: state_d = D_IDLE;
		endcase
	end

	// state register and done strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == D_DONE);
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			D_IDLE: begin
				if (req.start) begin
					mag_q  <= sample_mag(req.sample);
					neg_q  <= req.sample[SAMPLE_BITS-1];
					zero_q <= (req.sample == '0) || (req.count == '0) || (req.sum == '0);
					cnt_q  <= req.count;
					sum_q  <= req.sum;
				end
			end
			D_MUL: begin
				prod_q <= PROD_BITS'(cnt_q) * PROD_BITS'(mag_q);
			end
			D_CHK: begin
				ovf_q  <= ovf;
				rem_q  <= (SUM_BITS+1)'(prod_q >> INT_BITS);
				dsh_q  <= {prod_q[INT_BITS-1:0], {(FRAC_BITS+1){1'b0}}};
				quo_q  <= '0;
				iter_q <= '0;
			end
			D_ITER: begin
				rem_q  <= qbit ? (trial - {1'b0, sum_q}) : trial;
				quo_q  <= {quo_q[OUT_BITS-2:0], qbit};
				dsh_q  <= {dsh_q[OUT_BITS-2:0], 1'b0};
				iter_q <= iter_q + ITER_BITS'(1);
			end
			D_DONE: begin
				res_q <= res_d;
			end
			default: begin
			end
		endcase
	end

	assign rsp.done   = done_q;
	assign rsp.result = res_q;

endmodule

@@ rtl/sliding_window_agc_top.sv @@
// ----------------------------------------------------------------------------
// sliding_window_agc_top: streaming mean-absolute agc
// sample store, window sum and count, sequencer and output register
// ----------------------------------------------------------------------------
// Usage
//   in_ch carries one request per handshake: a sample (req_type 0, with
//   trace_last on the final sample of a trace) or a drain step (req_type 1).
//   out_ch returns gained samples in signed Q11.16; out_last marks the final
//   output of a trace. Output i leaves on the request carrying sample i+H,
//   or on drain requests after the trace has ended.
//   cfg_wr_en/cfg_wr_data write the half window H and start a fresh trace;
//   write only while the block is idle.
// Timing
//   a request that produces no output leaves the sequencer idle. One that
//   produces an output passes through two store reads, divider start,
//   product, overflow check, the 28 one-bit steps of the shared restoring
//   divider, the done strobe and the output state before out_ch.valid
//   rises; a zero sample, an empty window or an overflow skips the steps.
//   No new request is taken until the sequencer is back in idle.
//   in_ch.ready is high only while the sequencer is idle.
// Reset and stall
//   reset clears counts, sum and trace state and sets H to 64; the sample
//   store is not cleared. A result waits in the output register while
//   out_ch.ready is low; the next request is still taken, and a further
//   result waits in the sequencer until the register is free.
// ----------------------------------------------------------------------------
module sliding_window_agc_top
	import swagc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	swagc_in_if.sink            in_ch,
	swagc_out_if.source         out_ch,
	input  logic                cfg_wr_en,
	input  logic [CFG_BITS-1:0] cfg_wr_data
);

	seq_state_t                    state_q, state_d;
	logic [CFG_BITS-1:0]           h_q;
	logic [SUM_BITS-1:0]           sum_q;
	logic [CNT_BITS-1:0]           cnt_q;
	logic [CTR_BITS-1:0]           recv_q;
	logic [CTR_BITS-1:0]           emit_q;
	logic                          ended_q;
	logic                          last_q;
	logic signed [SAMPLE_BITS-1:0] cur_q;
	logic signed [SAMPLE_BITS-1:0] rd_data_q;
	logic                          out_valid_q;
	logic signed [OUT_BITS-1:0]    out_gain_q;
	logic                          out_last_q;

	logic signed [SAMPLE_BITS-1:0] mem [2**ADDR_BITS];

	logic [HW_BITS-1:0]   h_eff;
	logic                 in_fire;
	logic [CTR_BITS-1:0]  recv_inc;
	logic [CTR_BITS-1:0]  emit_inc;
	logic [CTR_BITS-1:0]  old_idx;
	logic                 rm_en;
	logic                 is_last;
	logic                 wr_en;
	logic                 rd_en;
	logic [ADDR_BITS-1:0] rd_addr;
	logic                 out_load;
	div_req_t             div_req;
	div_rsp_t             div_rsp;

	// effective half window
	always_comb begin
		if (h_q == '0) begin
			h_eff = HW_BITS'(1);
		end else if (CTR_BITS'(h_q) > CTR_BITS'(MAX_HALF_WINDOW)) begin
			h_eff = HW_BITS'(MAX_HALF_WINDOW);
		end else begin
			h_eff = HW_BITS'(h_q);
		end
	end

	// counter arithmetic
	assign in_fire  = in_ch.valid && in_ch.ready;
	assign recv_inc = recv_q + CTR_BITS'(1);
	assign emit_inc = emit_q + CTR_BITS'(1);
	assign old_idx  = emit_inc - CTR_BITS'(h_eff);
	assign rm_en    = emit_inc >= CTR_BITS'(h_eff);
	assign is_last  = ended_q && (emit_inc == recv_q);

	// sequencer next state and strobes
	always_comb begin
		state_d  = state_q;
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = emit_q[ADDR_BITS-1:0];
		out_load = 1'b0;
		div_req  = '{start: 1'b0, sample: cur_q, count: cnt_q, sum: sum_q};
		unique case (state_q)
			S_IDLE: begin
				if (in_fire && !cfg_wr_en) begin
					if (in_ch.req_type == REQ_SAMPLE) begin
						if (!ended_q) begin
							wr_en = 1'b1;
							if ((recv_inc - emit_q) > CTR_BITS'(h_eff)) state_d = S_RD_CUR;
						end
					end else if (ended_q && (recv_q != emit_q)) begin
						state_d = S_RD_CUR;
					end
				end
			end
			S_RD_CUR: begin
				rd_en   = 1'b1;
				state_d = S_RD_OLD;
			end
			S_RD_OLD: begin
				rd_en   = 1'b1;
				rd_addr = old_idx[ADDR_BITS-1:0];
				state_d = S_START;
			end
			S_START: begin
				div_req.start = 1'b1;
				state_d       = S_DIV;
			end
			S_DIV: begin
				if (div_rsp.done) state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || out_ch.ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// window sum, count and trace counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q     <= HALF_WINDOW_RESET;
			sum_q   <= '0;
			cnt_q   <= '0;
			recv_q  <= '0;
			emit_q  <= '0;
			ended_q <= 1'b0;
			last_q  <= 1'b0;
		end else if (cfg_wr_en) begin
			h_q     <= cfg_wr_data;
			sum_q   <= '0;
			cnt_q   <= '0;
			recv_q  <= '0;
			emit_q  <= '0;
			ended_q <= 1'b0;
		end else begin
			if (wr_en) begin
				if (in_ch.sample != '0) begin
					sum_q <= sum_q + SUM_BITS'(sample_mag(in_ch.sample));
					cnt_q <= cnt_q + CNT_BITS'(1);
				end
				recv_q  <= recv_inc;
				ended_q <= ended_q | in_ch.trace_last;
			end
			if (state_q == S_START) begin
				last_q <= is_last;
				if (is_last) begin
					sum_q   <= '0;
					cnt_q   <= '0;
					recv_q  <= '0;
					emit_q  <= '0;
					ended_q <= 1'b0;
				end else begin
					emit_q <= emit_inc;
					if (rm_en && (rd_data_q != '0)) begin
						sum_q <= sum_q - SUM_BITS'(sample_mag(rd_data_q));
						cnt_q <= cnt_q - CNT_BITS'(1);
					end
				end
			end
		end
	end

	// sample store, registered read
	always_ff @(posedge clk) begin
		if (wr_en) mem[recv_q[ADDR_BITS-1:0]] <= in_ch.sample;
		if (rd_en) rd_data_q <= mem[rd_addr];
	end

	// sample to gain
	always_ff @(posedge clk) begin
		if (state_q == S_RD_OLD) cur_q <= rd_data_q;
	end

	// shared gain unit
	swagc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_gain_q <= div_rsp.result;
			out_last_q <= last_q;
		end
	end

	assign in_ch.ready          = (state_q == S_IDLE);
	assign out_ch.valid         = out_valid_q;
	assign out_ch.gained_sample = out_gain_q;
	assign out_ch.out_last      = out_last_q;

endmodule

@@ sim/sliding_window_agc_top_tb.sv @@
// ----------------------------------------------------------------------------
// sliding_window_agc_top_tb: self-checking bench of the sliding window agc
// drives sample and drain requests with random bursts and gaps, stalls the
// output side on its own pattern, predicts every gained sample in a class
// and compares each one as it leaves the block
// ----------------------------------------------------------------------------
module sliding_window_agc_top_tb;
	import swagc_pkg::*;

	localparam int CLK_PERIOD    = 8;
	localparam int RESET_CYCLES  = 8;
	localparam int SETTLE_CYCLES = 64;
	localparam int HOLD_AFTER    = 60;
	localparam int HOLD_CYCLES   = 600;
	localparam int LIMIT_CYCLES  = 600000;
	localparam int TOTAL_ITEMS   = 1350;
	localparam int PHASE_ITEMS   = 30;
	localparam int WRAP_PHASE    = 2;
	localparam int RING_DEPTH    = 2 * MAX_HALF_WINDOW;

	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic [CFG_BITS-1:0]           CFG_TOP    = {CFG_BITS{1'b1}};

	// one predicted output sample
	typedef struct {
		logic signed [OUT_BITS-1:0] value;
		logic                       last;
	} gain_item_t;

	// window state of the agc and the gained samples still owed
	class agc_gain_model;
		logic [CFG_BITS-1:0]           half;
		logic signed [SAMPLE_BITS-1:0] ring [RING_DEPTH];
		longint unsigned               mag_sum;
		int unsigned                   nz_count;
		int unsigned                   rx_count;
		int unsigned                   tx_count;
		bit                            ended;
		gain_item_t                    gain_queue [$];
		int unsigned                   mismatches;

		function new();
			half = HALF_WINDOW_RESET;
			mismatches = 0;
			restart();
		endfunction

		function void restart();
			mag_sum = 0;
			nz_count = 0;
			rx_count = 0;
			tx_count = 0;
			ended = 0;
		endfunction

		function void write_half(logic [CFG_BITS-1:0] v);
			half = v;
			restart();
		endfunction

		// effective half window, zero acts as one
		function int unsigned span();
			if (half == 0) return 1;
			if (half > MAX_HALF_WINDOW) return MAX_HALF_WINDOW;
			return half;
		endfunction

		function longint unsigned abs_of(logic signed [SAMPLE_BITS-1:0] s);
			longint w;
			w = s;
			return (w < 0) ? -w : w;
		endfunction

		// count*|s|/sum in q11.16, round half away from zero, then the sign
		function logic signed [OUT_BITS-1:0] round_gain(logic signed [SAMPLE_BITS-1:0] s,
			longint unsigned cnt, longint unsigned total);
			longint unsigned num, quo, rest, top;
			int k;
			top = (64'd1 << (OUT_BITS - 1)) - 1;
			if (cnt == 0 || total == 0 || s == 0) return '0;
			num = cnt * abs_of(s);
			quo = num / total;
			rest = num % total;
			if (quo >= (64'd1 << INT_BITS)) begin
				quo = top + 1;
			end else begin
				for (k = 0; k <= FRAC_BITS; k++) begin
					quo = quo << 1;
					rest = rest << 1;
					if (rest >= total) begin
						rest = rest - total;
						quo = quo | 1;
					end
				end
				quo = (quo + 1) >> 1;
			end
			if (s > 0) begin
				if (quo > top) quo = top;
				return OUT_BITS'(quo);
			end
			if (quo > top + 1) quo = top + 1;
			return OUT_BITS'(-quo);
		endfunction

		// gain of the oldest pending sample, then slide the window front
		function gain_item_t next_gain(int unsigned h);
			gain_item_t g;
			logic signed [SAMPLE_BITS-1:0] old;
			g.value = round_gain(ring[tx_count % RING_DEPTH], nz_count, mag_sum);
			g.last = 1'b0;
			if (tx_count + 1 >= h) begin
				old = ring[(tx_count + 1 - h) % RING_DEPTH];
				if (old != 0) begin
					mag_sum = mag_sum - abs_of(old);
					nz_count--;
				end
			end
			tx_count++;
			return g;
		endfunction

		// note an accepted request
		function void take_request(logic kind, logic signed [SAMPLE_BITS-1:0] s, logic last);
			int unsigned h;
			gain_item_t g;
			h = span();
			if (kind == REQ_SAMPLE) begin
				if (ended) return;
				ring[rx_count % RING_DEPTH] = s;
				if (s != 0) begin
					mag_sum = mag_sum + abs_of(s);
					nz_count++;
				end
				rx_count++;
				if (last) ended = 1;
				if (rx_count - tx_count > h) gain_queue.push_back(next_gain(h));
			end else begin
				if (!ended || rx_count == tx_count) return;
				g = next_gain(h);
				if (tx_count == rx_count) begin
					g.last = 1'b1;
					restart();
				end
				gain_queue.push_back(g);
			end
		endfunction

		// compare one gained sample with the oldest prediction
		function void check_gain(logic signed [OUT_BITS-1:0] v, logic last);
			gain_item_t g;
			if (gain_queue.size() == 0) begin
				$display("%0t: unexpected gained sample, expected none, actual %0d last %b",
					$time, v, last);
				mismatches++;
				return;
			end
			g = gain_queue.pop_front();
			if (g.value !== v) begin
				$display("%0t: gained_sample mismatch, expected %0d, actual %0d",
					$time, g.value, v);
				mismatches++;
			end
			if (g.last !== last) begin
				$display("%0t: out_last mismatch, expected %b, actual %b", $time, g.last, last);
				mismatches++;
			end
		endfunction

		function int unsigned pending();
			return gain_queue.size();
		endfunction

		// drain requests still owed after the trace end
		function int unsigned backlog();
			return ended ? rx_count - tx_count : 0;
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [CFG_BITS-1:0] cfg_wr_data;

	swagc_in_if  in_ch ();
	swagc_out_if out_ch ();

	agc_gain_model gains;
	int unsigned   useful_items;
	int unsigned   results_seen;
	int unsigned   burst_left;

	sliding_window_agc_top DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	// clock
	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	// run limit
	initial begin
		#(CLK_PERIOD * LIMIT_CYCLES);
		$display("[FAIL] regression broken");
		$finish;
	end

	// check every gained sample taken by the receiver
	always @(posedge clk) begin
		if (arst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			gains.check_gain(out_ch.gained_sample, out_ch.out_last);
			results_seen++;
		end
	end

	// receiver stall pattern, with one long hold-off
	initial begin : receiver
		int unsigned mode, stretch, tick;
		bit held;
		out_ch.ready = 1'b0;
		held = 0;
		tick = 0;
		@(posedge arst_n);
		forever begin
			if (!held && results_seen >= HOLD_AFTER) begin
				held = 1;
				@(negedge clk);
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			mode = $urandom_range(0, 3);
			stretch = $urandom_range(20, 150);
			repeat (stretch) begin
				@(negedge clk);
				tick++;
				case (mode)
					0: out_ch.ready <= 1'b1;
					1: out_ch.ready <= $urandom_range(0, 1);
					2: out_ch.ready <= ($urandom_range(0, 3) == 0);
					default: out_ch.ready <= (tick % 5 != 0);
				endcase
			end
		end
	end

	// random sample; flavor 0 all zero, 1 mostly zero, else a wide mix
	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(int unsigned flavor);
		int unsigned roll;
		logic signed [SAMPLE_BITS-1:0] v;
		roll = $urandom_range(0, 99);
		if (flavor == 0) return '0;
		if (flavor == 1 && roll < 80) return '0;
		if (roll < 15) return '0;
		if (roll < 25) return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
		if (roll < 50) begin
			v = SAMPLE_BITS'($urandom_range(0, 511));
			return v - SAMPLE_BITS'(256);
		end
		return SAMPLE_BITS'($urandom);
	endfunction

	// offer one request and hold it until taken; bursts end in a random gap
	task automatic send(logic kind, logic signed [SAMPLE_BITS-1:0] s, logic last);
		int unsigned gap;
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.req_type <= kind;
		in_ch.sample <= s;
		in_ch.trace_last <= last;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		gains.take_request(kind, s, last);
		if (burst_left > 0) burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				@(negedge clk);
				in_ch.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	// stop offering and wait until every gained sample is out
	task automatic settle();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (gains.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_half(logic [CFG_BITS-1:0] v);
		settle();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		gains.write_half(v);
	endtask

	// one trace with its drains, sprinkled with requests the block ignores
	task automatic run_trace(int unsigned len, int unsigned flavor);
		int unsigned i;
		for (i = 0; i < len; i++) begin
			if ($urandom_range(0, 19) == 0)
				send(REQ_DRAIN, SAMPLE_BITS'($urandom), 1'($urandom));
			send(REQ_SAMPLE, pick_sample(flavor), i == len - 1);
			useful_items++;
		end
		if ($urandom_range(0, 3) == 0)
			send(REQ_SAMPLE, pick_sample(2), 1'($urandom));
		while (gains.backlog() != 0) begin
			if ($urandom_range(0, 24) == 0)
				send(REQ_SAMPLE, pick_sample(2), 1'($urandom));
			send(REQ_DRAIN, SAMPLE_BITS'($urandom), 1'($urandom));
			useful_items++;
		end
		if ($urandom_range(0, 3) == 0)
			send(REQ_DRAIN, SAMPLE_BITS'($urandom), 1'($urandom));
	endtask

	// half window of each phase: extremes first, then random
	function automatic logic [CFG_BITS-1:0] next_half(int unsigned idx);
		case (idx)
			0: return CFG_BITS'(1);
			1: return '0;
			2: return CFG_BITS'(3);
			3: return CFG_BITS'(17);
			4: return CFG_BITS'(MAX_HALF_WINDOW + 1);
			5: return CFG_TOP;
			default: return ($urandom_range(0, 5) == 0) ? '0 : CFG_BITS'($urandom_range(1, 40));
		endcase
	endfunction

	// main sequence
	initial begin
		int unsigned phase, goal, eff, len;
		logic [CFG_BITS-1:0] cfg;
		in_ch.valid = 1'b0;
		in_ch.req_type = REQ_SAMPLE;
		in_ch.sample = '0;
		in_ch.trace_last = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		arst_n = 1'b0;
		gains = new();
		useful_items = 0;
		results_seen = 0;
		burst_left = 1;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part at the reset half window
		send(REQ_DRAIN, SAMPLE_MIN, 1'b1);
		send(REQ_SAMPLE, SAMPLE_MAX, 1'b0);
		send(REQ_SAMPLE, SAMPLE_MIN, 1'b0);
		send(REQ_SAMPLE, '0, 1'b0);
		send(REQ_DRAIN, SAMPLE_BITS'(-1), 1'b1);
		send(REQ_SAMPLE, SAMPLE_BITS'(1), 1'b0);
		send(REQ_SAMPLE, SAMPLE_BITS'(-1), 1'b0);
		send(REQ_SAMPLE, SAMPLE_BITS'(-4000000), 1'b1);
		send(REQ_SAMPLE, SAMPLE_BITS'(77), 1'b0);
		while (gains.backlog() != 0) send(REQ_DRAIN, SAMPLE_MAX, 1'b0);
		send(REQ_DRAIN, '0, 1'b0);
		// empty window trace
		send(REQ_SAMPLE, '0, 1'b0);
		send(REQ_SAMPLE, '0, 1'b0);
		send(REQ_SAMPLE, '0, 1'b1);
		while (gains.backlog() != 0) send(REQ_DRAIN, '0, 1'b1);
		// single sample trace
		send(REQ_SAMPLE, SAMPLE_MAX, 1'b1);
		send(REQ_DRAIN, SAMPLE_MIN, 1'b0);

		// random phases
		phase = 0;
		while (useful_items < TOTAL_ITEMS) begin
			cfg = next_half(phase);
			set_half(cfg);
			eff = gains.span();
			if (phase == WRAP_PHASE) begin
				// short window, trace long enough to wrap the sample store
				run_trace($urandom_range(RING_DEPTH + 1, RING_DEPTH + 8), $urandom_range(1, 7));
			end else begin
				goal = useful_items + PHASE_ITEMS;
				while (useful_items < goal) begin
					len = $urandom_range(1, (eff > 40) ? 40 : 3 * eff + 4);
					run_trace(len, $urandom_range(0, 7));
				end
			end
			phase++;
		end

		settle();
		if (gains.mismatches == 0 && gains.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/swagc_pkg.sv
rtl/swagc_in_if.sv
rtl/swagc_out_if.sv
rtl/swagc_div.sv
rtl/sliding_window_agc_top.sv
sim/sliding_window_agc_top_tb.sv
